[rtl/d8_steepest_descent_direction_assert.svh]
// assertion macros for the d8 steepest descent direction block
// expects clk and rst_n in the scope where a macro is used
`ifndef D8_STEEPEST_DESCENT_DIRECTION_ASSERT_SVH
`define D8_STEEPEST_DESCENT_DIRECTION_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define D8SD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define D8SD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/d8sd_pkg.sv]
// shared constants and helpers for the d8 steepest descent direction block
// no dependencies
package d8sd_pkg;

    // parameter defaults
    localparam int MAX_COLUMNS_DEF = 1024;
    localparam int VALUE_BITS_DEF  = 32;

    // configuration port
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_INDEX_W = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_RASTER_COLUMNS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER_ONLY     = 2'd1;

    localparam logic [CFG_DATA_W-1:0] RASTER_COLUMNS_RESET = 11'd1024;
    localparam int                    MIN_COLUMNS          = 3;

    // direction code
    localparam int               DIR_W    = 4;
    localparam logic [DIR_W-1:0] DIR_NONE = 4'hF;
    localparam int               OUT_W    = 8;

    // drop weights in q16: orthogonal is a shift, diagonal is round(65536/sqrt2)
    localparam int          ORTHO_SHIFT = 16;
    localparam int          DIAG_W      = 17;
    localparam logic [15:0] W_DIAG      = 16'd46341;

    // result queue
    localparam int OUT_FIFO_DEPTH = 8;

    // window row of neighbor i, north first then clockwise
    function automatic logic [1:0] nb_row(logic [2:0] i);
        logic [1:0] r;
        case (i)
            3'd0, 3'd1, 3'd7: r = 2'd0;
            3'd2, 3'd6:       r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    // window column of neighbor i
    function automatic logic [1:0] nb_col(logic [2:0] i);
        logic [1:0] c;
        case (i)
            3'd0, 3'd4:       c = 2'd1;
            3'd1, 3'd2, 3'd3: c = 2'd2;
            default:          c = 2'd0;
        endcase
        return c;
    endfunction

endpackage

[rtl/d8_steepest_descent_direction.sv]
// d8 steepest descent direction over a streamed raster, single module
// depends on d8sd_pkg and d8_steepest_descent_direction_assert.svh
//
// usage
//   slave channel: one elevation item per handshake in raster order.
//   s_tdata carries the signed elevation, s_tuser the nodata flag and the
//   first-cell flag that restarts the raster at column 0, row 0.
//   master channel: one direction item for each input at column >= 1 and
//   row >= 1; it belongs to the cell one row and one column back. codes
//   0..7 run clockwise from north, 0xF means none (edge, nodata, or no
//   lower neighbor when lower_only is set).
//   configuration: raster_columns (index 0, clamped to 3..MAX_COLUMNS) and
//   lower_only (index 1); write only while the block is idle.
// timing
//   one item per cycle while s_tready is high. an accepted input passes the
//   line store read, window shift, drops, weighted drops, then a three-level
//   registered compare tree, and its result then enters the output queue.
//   the line store is one dual-row memory read and written once per item.
// reset and stall
//   reset clears the window, the position counters, the pipeline and the
//   queue and restores the register defaults; the line store is not cleared.
//   s_tready drops only when the eight-entry output queue plus the items in
//   flight could fill it, so a stalled receiver never loses a result.
`include "d8_steepest_descent_direction_assert.svh"

module d8_steepest_descent_direction #(
    parameter int MAX_COLUMNS = d8sd_pkg::MAX_COLUMNS_DEF,
    parameter int VALUE_BITS  = d8sd_pkg::VALUE_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // slave side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]  s_tdata,   // cell_value
    input  logic [1:0]                       s_tuser,   // cell_nodata, first_cell
    // master side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [d8sd_pkg::OUT_W-1:0]       m_tdata,   // direction, zero pad
    // configuration
    input  logic                             cfg_we,
    input  logic [d8sd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [d8sd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import d8sd_pkg::*;

    localparam int VB   = VALUE_BITS;
    localparam int CW   = VB + 1;                       // value plus nodata
    localparam int EW   = 2 * CW;                       // two rows per column
    localparam int XW   = $clog2(MAX_COLUMNS);
    localparam int CLW  = (XW + 1 > CFG_DATA_W) ? XW + 1 : CFG_DATA_W;
    localparam int PW   = VB + 1 + DIAG_W;              // weighted drop
    localparam int FAW  = $clog2(OUT_FIFO_DEPTH);
    localparam int FCW  = $clog2(OUT_FIFO_DEPTH + 1);
    localparam int YW   = 16;

    typedef struct packed {
        logic                 vld;
        logic [2:0]           idx;
        logic signed [PW-1:0] val;
    } node_t;

    // larger weighted drop wins, a tie keeps the lower index (left side)
    function automatic node_t pick(node_t a, node_t b);
        node_t r;
        r = a;
        if (b.vld && (!a.vld || ($signed(b.val) > $signed(a.val))))
            r = b;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    logic [CFG_DATA_W-1:0] raster_columns_reg;
    logic                  lower_only_reg;
    logic [XW-1:0]         col_reg, col_next;
    logic [YW-1:0]         row_reg, row_next;

    logic                  s1_vld_reg, s1_emit_reg, s1_edge_reg, s1_fwd_reg;
    logic [XW-1:0]         s1_x_reg;
    logic [CW-1:0]         s1_px_reg;
    logic [EW-1:0]         last_wr_reg;
    logic [EW-1:0]         rd_data_reg;
    logic [EW-1:0]         row_mem [MAX_COLUMNS];

    logic [CW-1:0]         win_reg [3][3];

    logic                  s2_emit_reg, s2_edge_reg;
    logic                  s3_emit_reg, s3_bad_reg;
    logic signed [VB:0]    d_reg [8];
    logic                  s4_emit_reg, s4_bad_reg;
    node_t                 leaf_reg [8];
    logic                  s5_emit_reg, s5_bad_reg;
    node_t                 lvl1_reg [4];
    logic                  s6_emit_reg, s6_bad_reg;
    node_t                 lvl2_reg [2];

    logic [DIR_W-1:0]      fifo_reg [OUT_FIFO_DEPTH];
    logic [FAW-1:0]        wr_ptr_reg, rd_ptr_reg;
    logic [FCW-1:0]        count_reg;

    // ---------------------------------------------------------------
    // input side and position tracking
    // ---------------------------------------------------------------
    logic                  accept, first_in, emit_in, edge_in, fwd_in;
    logic [XW-1:0]         x_eff;
    logic [YW-1:0]         y_eff;
    logic [CLW-1:0]        cols_lim, cols_ext, x_inc;
    logic [CW-1:0]         px_in;
    logic [2:0]            pending;
    logic [FCW:0]          occupancy;

    assign accept   = s_tvalid && s_tready;
    assign first_in = s_tuser[1];
    assign px_in    = {s_tuser[0], s_tdata[VB-1:0]};
    assign x_eff    = first_in ? '0 : col_reg;
    assign y_eff    = first_in ? '0 : row_reg;
    assign emit_in  = (x_eff != '0) && (y_eff != '0);
    assign edge_in  = (x_eff == XW'(1)) || (y_eff == YW'(1));
    assign fwd_in   = s1_vld_reg && (x_eff == s1_x_reg);

    // column count clamp
    always_comb
    begin
        cols_ext = CLW'(raster_columns_reg);
        if (cols_ext < CLW'(MIN_COLUMNS))
            cols_lim = CLW'(MIN_COLUMNS);
        else if (cols_ext > CLW'(MAX_COLUMNS))
            cols_lim = CLW'(MAX_COLUMNS);
        else
            cols_lim = cols_ext;
    end

    // next position with row wrap and saturating row count
    always_comb
    begin
        x_inc = CLW'({1'b0, x_eff}) + CLW'(1);
        if (x_inc >= cols_lim)
        begin
            col_next = '0;
            row_next = (y_eff != {YW{1'b1}}) ? y_eff + YW'(1) : y_eff;
        end
        else
        begin
            col_next = x_inc[XW-1:0];
            row_next = y_eff;
        end
    end

    // credit for the output queue: queued plus in flight
    assign pending   = 3'($countones({s1_emit_reg, s2_emit_reg, s3_emit_reg,
                                      s4_emit_reg, s5_emit_reg, s6_emit_reg}));
    assign occupancy = (FCW+1)'(count_reg) + (FCW+1)'(pending);
    assign s_tready  = occupancy < (FCW+1)'(OUT_FIFO_DEPTH);

    // ---------------------------------------------------------------
    // line store: row 0 in the low half, row 1 in the high half
    // ---------------------------------------------------------------
    logic [EW-1:0] entry, wr_entry;

    assign entry    = s1_fwd_reg ? last_wr_reg : rd_data_reg;
    assign wr_entry = {s1_px_reg, entry[EW-1:CW]};

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
            row_mem[s1_x_reg] <= wr_entry;
        if (accept)
            rd_data_reg <= row_mem[x_eff];
    end

    // ---------------------------------------------------------------
    // drops from the window centre
    // ---------------------------------------------------------------
    logic signed [VB:0] d_next [8];
    logic [CW-1:0]      nb;
    logic [CW-1:0]      z;
    logic               any_nd;

    always_comb
    begin
        z      = win_reg[1][1];
        any_nd = 1'b0;
        nb     = '0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                any_nd = any_nd | win_reg[r][c][VB];
        for (int i = 0; i < 8; i++)
        begin
            nb        = win_reg[nb_row(3'(i))][nb_col(3'(i))];
            d_next[i] = $signed({z[VB-1], z[VB-1:0]}) - $signed({nb[VB-1], nb[VB-1:0]});
        end
    end

    // ---------------------------------------------------------------
    // weighted drops and candidate marks
    // ---------------------------------------------------------------
    node_t leaf_next [8];

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            leaf_next[i].idx = 3'(i);
            leaf_next[i].vld = !(lower_only_reg && (d_reg[i][VB] || (d_reg[i] == '0)));
            if (i[0])
                leaf_next[i].val = d_reg[i] * $signed({1'b0, W_DIAG});
            else
                leaf_next[i].val = $signed({d_reg[i][VB], d_reg[i], {ORTHO_SHIFT{1'b0}}});
        end
    end

    // ---------------------------------------------------------------
    // compare tree and final code
    // ---------------------------------------------------------------
    node_t            lvl1_next [4];
    node_t            lvl2_next [2];
    node_t            fin;
    logic [DIR_W-1:0] dir_out;
    logic             push, pop;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            lvl1_next[k] = pick(leaf_reg[2*k], leaf_reg[2*k+1]);
        for (int k = 0; k < 2; k++)
            lvl2_next[k] = pick(lvl1_reg[2*k], lvl1_reg[2*k+1]);
        fin     = pick(lvl2_reg[0], lvl2_reg[1]);
        dir_out = (s6_bad_reg || !fin.vld) ? DIR_NONE : {1'b0, fin.idx};
    end

    assign push = s6_emit_reg;
    assign pop  = m_tvalid && m_tready;

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raster_columns_reg <= RASTER_COLUMNS_RESET;
            lower_only_reg     <= 1'b1;
            col_reg            <= '0;
            row_reg            <= '0;
            s1_vld_reg         <= 1'b0;
            s1_emit_reg        <= 1'b0;
            s1_fwd_reg         <= 1'b0;
            s2_emit_reg        <= 1'b0;
            s3_emit_reg        <= 1'b0;
            s4_emit_reg        <= 1'b0;
            s5_emit_reg        <= 1'b0;
            s6_emit_reg        <= 1'b0;
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= '0;
            count_reg          <= '0;
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    win_reg[r][c] <= '0;
        end
        else
        begin
            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_RASTER_COLUMNS: raster_columns_reg <= cfg_data;
                    REG_LOWER_ONLY:     lower_only_reg     <= cfg_data[0];
                    default:            ;
                endcase
            end
            // position
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            // pipeline flags
            s1_vld_reg  <= accept;
            s1_emit_reg <= accept && emit_in;
            s1_fwd_reg  <= accept && fwd_in;
            s2_emit_reg <= s1_emit_reg;
            s3_emit_reg <= s2_emit_reg;
            s4_emit_reg <= s3_emit_reg;
            s5_emit_reg <= s4_emit_reg;
            s6_emit_reg <= s5_emit_reg;
            // window shift with the new column
            if (s1_vld_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= entry[CW-1:0];
                win_reg[1][2] <= entry[EW-1:CW];
                win_reg[2][2] <= s1_px_reg;
            end
            // output queue pointers
            if (push)
                wr_ptr_reg <= wr_ptr_reg + FAW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + FAW'(1);
            if (push && !pop)
                count_reg <= count_reg + FCW'(1);
            else if (pop && !push)
                count_reg <= count_reg - FCW'(1);
        end
    end

    // ---------------------------------------------------------------
    // payload stages
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg    <= x_eff;
            s1_px_reg   <= px_in;
            s1_edge_reg <= edge_in;
        end
        if (s1_vld_reg)
            last_wr_reg <= wr_entry;
        s2_edge_reg <= s1_edge_reg;
        s3_bad_reg  <= s2_edge_reg || any_nd;
        s4_bad_reg  <= s3_bad_reg;
        s5_bad_reg  <= s4_bad_reg;
        s6_bad_reg  <= s5_bad_reg;
        for (int i = 0; i < 8; i++)
        begin
            d_reg[i]    <= d_next[i];
            leaf_reg[i] <= leaf_next[i];
        end
        for (int k = 0; k < 4; k++)
            lvl1_reg[k] <= lvl1_next[k];
        for (int k = 0; k < 2; k++)
            lvl2_reg[k] <= lvl2_next[k];
        if (push)
            fifo_reg[wr_ptr_reg] <= dir_out;
    end

    // output side
    assign m_tvalid = count_reg != '0;
    assign m_tdata  = OUT_W'(fifo_reg[rd_ptr_reg]);

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `D8SD_ASSERT_NOW(a_queue_no_overflow, push && !pop,
        count_reg < FCW'(OUT_FIFO_DEPTH), "output queue overflow")
    `D8SD_ASSERT_NOW(a_credit_bound, 1'b1,
        occupancy <= (FCW+1)'(OUT_FIFO_DEPTH), "queue plus in-flight items exceed depth")
    `D8SD_ASSERT_NOW(a_fwd_after_write, s1_fwd_reg,
        $past(s1_vld_reg), "line store forward without a write in the prior cycle")
    `D8SD_ASSERT_NEXT(a_first_item_column, accept && first_in,
        col_reg == XW'(1), "first item did not restart the column count")
    `D8SD_ASSERT_NOW(a_direction_legal, m_tvalid,
        (m_tdata[3] == 1'b0) || (m_tdata[3:0] == DIR_NONE), "illegal direction code")

endmodule

[bench/tb_top.sv]
// testbench for d8_steepest_descent_direction: streams elevation rasters, predicts
// every flow direction on the side and checks each output item in order
// depends on d8sd_pkg and the rtl of the block
module tb_top;

    import d8sd_pkg::*;

    localparam int VALUE_W       = VALUE_BITS_DEF;
    localparam int LINE_CELLS    = MAX_COLUMNS_DEF;
    localparam int ROW_CAP       = 65535;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_CELLS  = 1000;
    localparam int PRINT_LIMIT   = 50;

    localparam longint ORTHO_WEIGHT = 65536;
    localparam longint DIAG_WEIGHT  = 46341;

    // indexes that hold no register
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic signed [VALUE_W-1:0] HEIGHT_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] HEIGHT_MAX = 32'sh7FFF_FFFF;

    typedef enum logic [3:0] {
        FLOW_N = 4'd0, FLOW_NE, FLOW_E, FLOW_SE, FLOW_S, FLOW_SW, FLOW_W, FLOW_NW,
        FLOW_NONE = 4'hF
    } flow_dir_t;

    typedef enum int {HEIGHT_SMALL, HEIGHT_FULL, HEIGHT_EXTREME, HEIGHT_MIXED} height_mode_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [VALUE_W-1:0]     s_tdata   = '0;    // cell_value
    logic [1:0]             s_tuser   = '0;    // cell_nodata, first_cell
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_W-1:0]       m_tdata;           // direction, zero pad
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    d8_steepest_descent_direction uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: two line stores, the 3x3 window, raster position
    logic signed [VALUE_W-1:0] line_height [2][LINE_CELLS];
    logic                      line_nodata [2][LINE_CELLS];
    logic signed [VALUE_W-1:0] win_height [3][3];
    logic                      win_nodata [3][3];
    int unsigned               col_pos;
    int unsigned               row_pos;
    logic [CFG_DATA_W-1:0]     columns_reg;
    logic                      lower_only_reg;
    flow_dir_t                 expected_dirs [$];

    // run control and bookkeeping
    bit sender_gaps;
    bit receiver_stalls;
    int hold_request;
    int cells_sent;
    int results_checked;
    int flow_codes;
    int mismatch_count;

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        // keep the log short when a whole run goes wrong
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch: %s", what);
    endtask

    // steepest weighted drop from the window centre, lower index wins ties
    function automatic flow_dir_t steepest_dir();
        longint centre;
        longint drop;
        longint best_drop;
        int     best;
        int     r;
        int     c;
        best = -1;
        best_drop = 0;
        if (win_nodata[1][1])
            return FLOW_NONE;
        centre = win_height[1][1];
        for (int i = 0; i < 8; i++)
        begin
            case (i)
                0: begin r = 0; c = 1; end
                1: begin r = 0; c = 2; end
                2: begin r = 1; c = 2; end
                3: begin r = 2; c = 2; end
                4: begin r = 2; c = 1; end
                5: begin r = 2; c = 0; end
                6: begin r = 1; c = 0; end
                default: begin r = 0; c = 0; end
            endcase
            if (win_nodata[r][c])
                return FLOW_NONE;
            drop = centre - longint'(win_height[r][c]);
            if (lower_only_reg && drop <= 0)
                continue;
            drop = drop * ((i % 2 == 1) ? DIAG_WEIGHT : ORTHO_WEIGHT);
            if (best < 0 || drop > best_drop)
            begin
                best = i;
                best_drop = drop;
            end
        end
        return (best < 0) ? FLOW_NONE : flow_dir_t'(best);
    endfunction

    // advance the predictor by one accepted cell
    function automatic void predict_cell(logic signed [VALUE_W-1:0] height, logic nodata,
                                         logic restart);
        int unsigned cols;
        int unsigned x;
        cols = columns_reg;
        if (cols < MIN_COLUMNS)
            cols = MIN_COLUMNS;
        if (cols > LINE_CELLS)
            cols = LINE_CELLS;
        if (restart)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        if (x >= LINE_CELLS)
            x = LINE_CELLS - 1;

        // slide the window one column and pull in the new column
        for (int r = 0; r < 3; r++)
        begin
            win_height[r][0] = win_height[r][1];
            win_nodata[r][0] = win_nodata[r][1];
            win_height[r][1] = win_height[r][2];
            win_nodata[r][1] = win_nodata[r][2];
        end
        win_height[0][2] = line_height[0][x];
        win_nodata[0][2] = line_nodata[0][x];
        win_height[1][2] = line_height[1][x];
        win_nodata[1][2] = line_nodata[1][x];
        win_height[2][2] = height;
        win_nodata[2][2] = nodata;
        line_height[0][x] = line_height[1][x];
        line_nodata[0][x] = line_nodata[1][x];
        line_height[1][x] = height;
        line_nodata[1][x] = nodata;

        // edge centres give no flow
        if (x >= 1 && row_pos >= 1)
            expected_dirs.push_back((x == 1 || row_pos == 1) ? FLOW_NONE : steepest_dir());

        // row wrap with a saturating row counter
        x++;
        if (x >= cols)
        begin
            x = 0;
            if (row_pos < ROW_CAP)
                row_pos++;
        end
        col_pos = x;
    endfunction

    function automatic int random_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic signed [VALUE_W-1:0] random_height(height_mode_t mode);
        height_mode_t pick;
        int           corner;
        pick = mode;
        if (pick == HEIGHT_MIXED)
            pick = height_mode_t'($urandom_range(0, 2));
        if (pick == HEIGHT_SMALL)
            return $signed($urandom_range(0, 8)) - 4;
        if (pick == HEIGHT_FULL)
            return $urandom;
        corner = $urandom_range(0, 3);
        if (corner == 0)
            return HEIGHT_MIN;
        if (corner == 1)
            return HEIGHT_MAX;
        return (corner == 2) ? 0 : -1;
    endfunction

    // offer one cell and hold it until accepted
    task automatic send_cell(logic signed [VALUE_W-1:0] height, logic nodata, logic restart);
        int gap;
        gap = sender_gaps ? random_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= height;
        s_tuser  <= {restart, nodata};
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_row(logic signed [VALUE_W-1:0] left, logic signed [VALUE_W-1:0] middle,
                            logic signed [VALUE_W-1:0] right);
        send_cell(left, 1'b0, 1'b0);
        send_cell(middle, 1'b0, 1'b0);
        send_cell(right, 1'b0, 1'b0);
    endtask

    // stream of random cells, optionally opening a fresh raster
    task automatic send_raster(int cells, height_mode_t mode, int nodata_pct,
                               int restart_permille, bit fresh);
        for (int n = 0; n < cells; n++)
            send_cell(random_height(mode), $urandom_range(0, 99) < nodata_pct,
                      (fresh && n == 0) || ($urandom_range(1, 1000) <= restart_permille));
    endtask

    // drop valid and wait until every expected direction is in, then let the block settle
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_dirs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (index == REG_RASTER_COLUMNS)
            columns_reg = value;
        else if (index == REG_LOWER_ONLY)
            lower_only_reg = value[0];
    endtask

    // reset widths: three full rows, which also writes every line store entry
    task automatic test_full_width_rows();
        send_raster(3 * LINE_CELLS + 4, HEIGHT_MIXED, 3, 0, 1'b1);
    endtask

    // hand-built 3-column windows: extremes, ties, plateau, nodata
    task automatic test_directed_windows();
        write_reg(REG_RASTER_COLUMNS, 11'd1);
        write_reg(REG_LOWER_ONLY, 11'd0);
        send_cell(0, 1'b0, 1'b1);
        send_cell(HEIGHT_MAX, 1'b0, 1'b0);
        send_cell(20, 1'b0, 1'b0);
        send_row(-5, HEIGHT_MIN, 7);
        send_row(4, 9, 1);
        send_row(HEIGHT_MAX, 3, HEIGHT_MIN);

        // north and northeast weighted drops are equal, north must win
        write_reg(REG_LOWER_ONLY, 11'd1);
        send_cell(100000, 1'b0, 1'b1);
        send_cell(53659, 1'b0, 1'b0);
        send_cell(34464, 1'b0, 1'b0);
        send_row(100000, 100000, 100000);
        send_row(100000, 100000, 100000);
        // flat window, nothing lower
        send_row(100000, 100000, 100000);
        // nodata neighbor below, then nodata centre
        send_cell(100000, 1'b0, 1'b0);
        send_cell(100000, 1'b1, 1'b0);
        send_cell(100000, 1'b0, 1'b0);
        send_row(7, 7, 7);
    endtask

    // clamping at both ends and writes to unused indexes
    task automatic test_register_edges();
        write_reg(REG_RASTER_COLUMNS, '1);
        write_reg(REG_LOWER_ONLY, 11'd0);
        write_reg(REG_SPARE_A, 11'd5);
        write_reg(REG_SPARE_B, '1);
        send_raster(LINE_CELLS + 40, HEIGHT_SMALL, 2, 0, 1'b1);
        write_reg(REG_RASTER_COLUMNS, 11'd0);
        send_raster(15, HEIGHT_MIXED, 0, 0, 1'b1);
        write_reg(REG_RASTER_COLUMNS, 11'd2);
        send_raster(12, HEIGHT_SMALL, 0, 0, 1'b1);
    endtask

    // shrink past the current column, then widen, both mid-raster
    task automatic test_column_change();
        write_reg(REG_RASTER_COLUMNS, 11'd6);
        write_reg(REG_LOWER_ONLY, 11'd1);
        send_raster(17, HEIGHT_SMALL, 0, 0, 1'b1);
        write_reg(REG_RASTER_COLUMNS, 11'd4);
        send_raster(18, HEIGHT_SMALL, 0, 0, 1'b0);
        write_reg(REG_RASTER_COLUMNS, 11'd9);
        send_raster(30, HEIGHT_MIXED, 0, 0, 1'b0);
    endtask

    // receiver holds off long enough for the block to fill and stall its input
    task automatic test_output_backpressure();
        write_reg(REG_RASTER_COLUMNS, 11'd5);
        write_reg(REG_LOWER_ONLY, 11'd0);
        sender_gaps = 1'b0;
        hold_request = 300;
        send_raster(80, HEIGHT_FULL, 0, 0, 1'b1);
        sender_gaps = 1'b1;
    endtask

    // random rasters: mostly narrow, some wider, some nodata heavy, a few stray restarts
    task automatic test_random_rasters();
        int start;
        int cols;
        int rows;
        int pick;
        start = cells_sent;
        while (cells_sent - start < RANDOM_CELLS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
                cols = $urandom_range(0, 2);
            else if (pick < 4)
                cols = $urandom_range(13, 48);
            else
                cols = $urandom_range(3, 10);
            write_reg(REG_RASTER_COLUMNS, cols);
            write_reg(REG_LOWER_ONLY, $urandom_range(0, 1));
            sender_gaps = ($urandom_range(0, 3) != 0);
            receiver_stalls = ($urandom_range(0, 3) != 0);
            if (cols < MIN_COLUMNS)
                cols = MIN_COLUMNS;
            rows = $urandom_range(3, 8);
            send_raster(cols * rows + $urandom_range(0, cols - 1),
                        height_mode_t'($urandom_range(0, 3)),
                        ($urandom_range(0, 3) == 0) ? 20 : 2, 5, 1'b1);
        end
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // narrow raster tall enough to pin the row counter, then a fresh raster
    task automatic test_row_saturation();
        write_reg(REG_RASTER_COLUMNS, 11'd3);
        write_reg(REG_LOWER_ONLY, 11'd0);
        sender_gaps = 1'b0;
        receiver_stalls = 1'b0;
        send_raster((ROW_CAP + 5) * 3, HEIGHT_SMALL, 1, 0, 1'b1);
        send_raster(12, HEIGHT_FULL, 0, 0, 1'b1);
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
    endtask

    // predictor follows every accepted cell
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            predict_cell(s_tdata, s_tuser[0], s_tuser[1]);
            cells_sent++;
        end
    end

    // compare each output item with the oldest expected direction
    always @(posedge clk)
    begin : direction_check
        flow_dir_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_dirs.size() == 0)
                report_mismatch($sformatf("direction %0h with nothing expected",
                                          m_tdata[DIR_W-1:0]));
            else
            begin
                want = expected_dirs.pop_front();
                results_checked++;
                if (want != FLOW_NONE)
                    flow_codes++;
                if (m_tdata[DIR_W-1:0] != want)
                    report_mismatch($sformatf("result %0d: direction %0h, expected %0h",
                                              results_checked, m_tdata[DIR_W-1:0], want));
            end
        end
    end

    // receiver: random stalls, or one long hold when requested
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                stall_left = hold_request;
                hold_request = 0;
            end
            else if (stall_left == 0 && receiver_stalls && $urandom_range(0, 99) < 30)
                stall_left = random_gap();
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no traffic at all
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    // test sequence
    initial
    begin : main
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                win_height[r][c] = '0;
                win_nodata[r][c] = 1'b0;
            end
        end
        for (int r = 0; r < 2; r++)
        begin
            for (int c = 0; c < LINE_CELLS; c++)
            begin
                line_height[r][c] = '0;
                line_nodata[r][c] = 1'b0;
            end
        end
        col_pos = 0;
        row_pos = 0;
        columns_reg = RASTER_COLUMNS_RESET;
        lower_only_reg = 1'b1;
        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        hold_request = 0;
        cells_sent = 0;
        results_checked = 0;
        flow_codes = 0;
        mismatch_count = 0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_full_width_rows();
        test_directed_windows();
        test_register_edges();
        test_column_change();
        test_output_backpressure();
        test_random_rasters();
        test_row_saturation();
        settle();

        $display("summary: %0d cells streamed, %0d directions checked, %0d with a flow code",
                 cells_sent, results_checked, flow_codes);
        $display("summary: widths 3 to 1024 with clamping, both drop modes, row counter capped");
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
